// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl of the dedup table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VDIT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define VDIT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/vdit_pkg.sv -----
// shared constants, codes and control structs of the vector dedup table
`default_nettype none

package vdit_pkg;

    localparam int BUFFER_WORDS = 4096;
    localparam int TABLE_SLOTS  = 1024;

    localparam int BUF_AW   = $clog2(BUFFER_WORDS);
    localparam int TBL_AW   = $clog2(TABLE_SLOTS);
    localparam int FILL_W   = $clog2(BUFFER_WORDS + 2);
    localparam int SUM_W    = FILL_W + 1;
    localparam int ELEM_W   = 64;
    localparam int OFFSET_W = 12;
    localparam int STATUS_W = 2;
    localparam int TALLY_W  = 3;

    localparam logic [ELEM_W-1:0] MIX_CONST     = 64'h517cc1b727220a95;
    localparam logic [ELEM_W-1:0] NEG_ZERO_BITS = 64'h8000000000000000;

    localparam logic [TALLY_W-1:0] TALLY_MAX     = 3'd4;
    localparam logic [TALLY_W-1:0] TALLY_SEEDED  = 3'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUFFER_FULL = 2'd2;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic hash;
        logic probe_init;
        logic probe_read;
        logic probe_next;
        logic report_hit;
        logic report_tfull;
        logic report_bfull;
        logic insert;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic last_flag;
        logic slot_empty;
        logic key_match;
        logic probe_last;
        logic buf_fits;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/vdit_ctrl.sv -----
// controller state machine of the vector dedup table
`default_nettype none

module vdit_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire vdit_pkg::dp_stat_t stat,
    output vdit_pkg::dp_cmd_t      cmd,
    output logic                   busy
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_HASH    = 3'd2;
    localparam logic [2:0] S_LOOKUP  = 3'd3;
    localparam logic [2:0] S_PROBE   = 3'd4;
    localparam logic [2:0] S_CHECK   = 3'd5;
    localparam logic [2:0] S_RESOLVE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = stat.last_flag ? S_LOOKUP : S_IDLE;
            end
            S_LOOKUP:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.probe_read = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.slot_empty)
                begin
                    state_next = S_RESOLVE;
                end
                else if (stat.key_match)
                begin
                    cmd.report_hit = 1'b1;
                    cmd.finish     = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.probe_last)
                begin
                    cmd.report_tfull = 1'b1;
                    cmd.finish       = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_RESOLVE:
            begin
                if (stat.buf_fits)
                begin
                    cmd.insert = 1'b1;
                end
                else
                begin
                    cmd.report_bfull = 1'b1;
                end
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/vdit_dp.sv -----
// datapath of the vector dedup table: hashes, slot table, value store, results
`default_nettype none

module vdit_dp
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire vdit_pkg::dp_cmd_t                 cmd,
    output vdit_pkg::dp_stat_t                     stat,
    input  wire logic [vdit_pkg::ELEM_W-1:0]       element_bits,
    input  wire logic                              last_element,
    output logic                                   done,
    output logic      [vdit_pkg::OFFSET_W-1:0]     offset,
    output logic                                   seen_before,
    output logic      [vdit_pkg::STATUS_W-1:0]     status
);

    typedef struct packed {
        logic                              valid;
        logic [vdit_pkg::ELEM_W-1:0]       key;
        logic [vdit_pkg::OFFSET_W-1:0]     offset;
    } slot_t;

    slot_t                              slot_mem [vdit_pkg::TABLE_SLOTS];
    logic [vdit_pkg::ELEM_W-1:0]        value_mem [vdit_pkg::BUFFER_WORDS];

    logic [vdit_pkg::ELEM_W-1:0]        elem_reg;
    logic [vdit_pkg::ELEM_W-1:0]        sum_reg;
    logic                               last_reg;
    logic [vdit_pkg::ELEM_W-1:0]        hz_reg;
    logic [vdit_pkg::ELEM_W-1:0]        hf_reg;
    logic [vdit_pkg::TALLY_W-1:0]       tally_reg;
    logic [vdit_pkg::FILL_W-1:0]        fill_reg;
    logic [vdit_pkg::FILL_W-1:0]        vlen_reg;
    logic [vdit_pkg::TBL_AW-1:0]        clr_idx_reg;
    logic [vdit_pkg::ELEM_W-1:0]        key_reg;
    logic [vdit_pkg::TBL_AW-1:0]        probe_idx_reg;
    logic [vdit_pkg::TBL_AW-1:0]        probe_cnt_reg;
    slot_t                              rd_reg;
    logic                               done_reg;
    logic [vdit_pkg::OFFSET_W-1:0]      offset_reg;
    logic                               seen_reg;
    logic [vdit_pkg::STATUS_W-1:0]      status_reg;

    logic [vdit_pkg::ELEM_W-1:0]        elem_fold;
    logic [vdit_pkg::SUM_W-1:0]         end_sum;
    logic                               stage_ok;
    logic [vdit_pkg::ELEM_W-1:0]        hz_mix;
    logic [vdit_pkg::ELEM_W-1:0]        hf_mix;
    logic [vdit_pkg::ELEM_W-1:0]        key_sel;
    logic                               slot_we;
    logic [vdit_pkg::TBL_AW-1:0]        slot_waddr;
    slot_t                              slot_wdata;

    assign elem_fold = (element_bits == vdit_pkg::NEG_ZERO_BITS) ? '0 : element_bits;
    assign end_sum   = {1'b0, fill_reg} + {1'b0, vlen_reg};
    assign stage_ok  = (end_sum < vdit_pkg::SUM_W'(vdit_pkg::BUFFER_WORDS));

    assign hz_mix = hz_reg ^ (sum_reg + (hz_reg << 6) + (hz_reg >> 2));
    assign hf_mix = hf_reg ^ (sum_reg + (hf_reg << 6) + (hf_reg >> 2));
    assign key_sel = (tally_reg == vdit_pkg::TALLY_SEEDED) ? hf_reg : hz_reg;

    // value store, written as elements arrive
    always_ff @(posedge clk)
    begin
        if (cmd.accept && stage_ok)
        begin
            value_mem[end_sum[vdit_pkg::BUF_AW-1:0]] <= element_bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            elem_reg <= elem_fold;
            sum_reg  <= elem_fold + vdit_pkg::MIX_CONST;
            last_reg <= last_element;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg    <= '0;
            hf_reg    <= '0;
            tally_reg <= '0;
            vlen_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            hz_reg    <= '0;
            hf_reg    <= '0;
            tally_reg <= '0;
            vlen_reg  <= '0;
        end
        else
        begin
            if (cmd.accept && (vlen_reg <= vdit_pkg::FILL_W'(vdit_pkg::BUFFER_WORDS)))
            begin
                vlen_reg <= vlen_reg + 1'b1;
            end
            if (cmd.hash)
            begin
                if (tally_reg == '0)
                begin
                    hz_reg <= sum_reg;
                    hf_reg <= elem_reg;
                end
                else
                begin
                    hz_reg <= hz_mix;
                    hf_reg <= hf_mix;
                end
                if (tally_reg < vdit_pkg::TALLY_MAX)
                begin
                    tally_reg <= tally_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cmd.insert)
            begin
                fill_reg <= end_sum[vdit_pkg::FILL_W-1:0];
            end
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    // probe walk
    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            key_reg       <= key_sel;
            probe_idx_reg <= key_sel[vdit_pkg::TBL_AW-1:0];
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            probe_idx_reg <= probe_idx_reg + 1'b1;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
    end

    // slot table: clearing pass or insertion on the write port
    always_comb
    begin
        slot_we    = cmd.clear_step | cmd.insert;
        slot_waddr = cmd.clear_step ? clr_idx_reg : probe_idx_reg;
        slot_wdata = '0;
        if (cmd.insert)
        begin
            slot_wdata.valid  = 1'b1;
            slot_wdata.key    = key_reg;
            slot_wdata.offset = fill_reg[vdit_pkg::OFFSET_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (cmd.probe_read)
        begin
            rd_reg <= slot_mem[probe_idx_reg];
        end
    end

    always_comb
    begin
        stat.clear_last = (clr_idx_reg == vdit_pkg::TBL_AW'(vdit_pkg::TABLE_SLOTS - 1));
        stat.last_flag  = last_reg;
        stat.slot_empty = !rd_reg.valid;
        stat.key_match  = (rd_reg.key == key_reg);
        stat.probe_last = (probe_cnt_reg == vdit_pkg::TBL_AW'(vdit_pkg::TABLE_SLOTS - 1));
        stat.buf_fits   = (end_sum <= vdit_pkg::SUM_W'(vdit_pkg::BUFFER_WORDS));
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report_hit | cmd.report_tfull | cmd.report_bfull | cmd.insert;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report_hit)
        begin
            offset_reg <= rd_reg.offset;
            seen_reg   <= 1'b1;
            status_reg <= vdit_pkg::ST_OK;
        end
        else if (cmd.report_tfull)
        begin
            offset_reg <= '0;
            seen_reg   <= 1'b0;
            status_reg <= vdit_pkg::ST_TABLE_FULL;
        end
        else if (cmd.report_bfull)
        begin
            offset_reg <= '0;
            seen_reg   <= 1'b0;
            status_reg <= vdit_pkg::ST_BUFFER_FULL;
        end
        else if (cmd.insert)
        begin
            offset_reg <= fill_reg[vdit_pkg::OFFSET_W-1:0];
            seen_reg   <= 1'b0;
            status_reg <= vdit_pkg::ST_OK;
        end
    end

    assign done        = done_reg;
    assign offset      = offset_reg;
    assign seen_before = seen_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

// ----- rtl/core/vector_dedup_intern_table.sv -----
// Vector dedup table, top level. Elements of a vector are requested one at a time with
// start while busy is low; last_element marks the final one. Each element is accepted,
// then the hash is updated. After the last element the table is walked by linear probing
// through a slot memory with a write and a read port: a setup step, a read and a check
// per slot visited, then an insert or a full-buffer report once an empty slot is found.
// One result per vector appears on offset, seen_before and status for exactly one cycle
// with done high; the receiver cannot stall it, and busy is low again in that same cycle.
// After reset the slot table is cleared, one slot per cycle, before a request is taken.
`default_nettype none

`include "assert_macros.svh"

module vector_dedup_intern_table
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [vdit_pkg::ELEM_W-1:0]       element_bits,
    input  wire logic                              last_element,
    output logic                                   done,
    output logic      [vdit_pkg::OFFSET_W-1:0]     offset,
    output logic                                   seen_before,
    output logic      [vdit_pkg::STATUS_W-1:0]     status
);

    vdit_pkg::dp_cmd_t  cmd;
    vdit_pkg::dp_stat_t stat;

    vdit_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    vdit_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .element_bits (element_bits),
        .last_element (last_element),
        .done         (done),
        .offset       (offset),
        .seen_before  (seen_before),
        .status       (status)
    );

    `VDIT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `VDIT_ASSERT_NXT(a_done_single, done, !done)
    `VDIT_ASSERT_IMP(a_done_idle, done, !busy)
    `VDIT_ASSERT_IMP(a_hit_ok, done && seen_before, status == vdit_pkg::ST_OK)

endmodule

`default_nettype wire

// ----- verif/vector_dedup_intern_table_tb.sv -----
// self-checking testbench for the vector dedup table: directed, random and table fill runs
`timescale 1ns / 1ps

module vector_dedup_intern_table_tb;

    localparam int IDLE_LIMIT   = 10000;
    localparam int RANDOM_ITEMS = 60;
    localparam int TAIL_CYCLES  = 2 * vdit_pkg::TABLE_SLOTS + 64;
    localparam int PAST_MAX     = 300;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [vdit_pkg::ELEM_W-1:0]   element_bits;
    logic                          last_element;
    logic                          done;
    logic [vdit_pkg::OFFSET_W-1:0] offset;
    logic                          seen_before;
    logic [vdit_pkg::STATUS_W-1:0] status;

    typedef struct packed {
        logic [vdit_pkg::OFFSET_W-1:0] offset;
        logic                          seen;
        logic [vdit_pkg::STATUS_W-1:0] status;
    } lookup_t;

    class dedup_scoreboard;
        logic [vdit_pkg::ELEM_W-1:0] zero_seed;
        logic [vdit_pkg::ELEM_W-1:0] first_seed;
        int                          tally;
        int                          run_words;
        int                          fill;
        int                          free_slots;
        bit                          slot_used [vdit_pkg::TABLE_SLOTS];
        logic [vdit_pkg::ELEM_W-1:0] slot_key [vdit_pkg::TABLE_SLOTS];
        int                          slot_ofs [vdit_pkg::TABLE_SLOTS];
        lookup_t                     awaited[$];
        int                          errors;
        int                          n_elems;
        int                          n_vectors;
        int                          n_hits;
        int                          n_inserts;
        int                          n_tfull;
        int                          n_bfull;

        function new();
            zero_seed  = '0;
            first_seed = '0;
            tally      = 0;
            run_words  = 0;
            fill       = 0;
            free_slots = vdit_pkg::TABLE_SLOTS;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            errors     = 0;
            n_elems    = 0;
            n_vectors  = 0;
            n_hits     = 0;
            n_inserts  = 0;
            n_tfull    = 0;
            n_bfull    = 0;
        endfunction

        function logic [vdit_pkg::ELEM_W-1:0] mix_step(logic [vdit_pkg::ELEM_W-1:0] l,
                                                       logic [vdit_pkg::ELEM_W-1:0] r);
            return l ^ (r + vdit_pkg::MIX_CONST + (l << 6) + (l >> 2));
        endfunction

        function logic [vdit_pkg::ELEM_W-1:0] fold(logic [vdit_pkg::ELEM_W-1:0] e);
            return (e == vdit_pkg::NEG_ZERO_BITS) ? '0 : e;
        endfunction

        function void note_element(logic [vdit_pkg::ELEM_W-1:0] raw, logic last);
            logic [vdit_pkg::ELEM_W-1:0] e;
            logic [vdit_pkg::ELEM_W-1:0] key;
            lookup_t                     r;
            int                          idx;
            int                          free_idx;
            int                          i;
            bit                          hit;
            e = fold(raw);
            n_elems++;
            if (run_words <= vdit_pkg::BUFFER_WORDS) run_words++;
            if (tally == 0)
            begin
                zero_seed  = mix_step('0, e);
                first_seed = e;
            end
            else
            begin
                zero_seed  = mix_step(zero_seed, e);
                first_seed = mix_step(first_seed, e);
            end
            if (tally < 4) tally++;
            if (!last) return;

            key      = (tally == 3) ? first_seed : zero_seed;
            r.offset = '0;
            r.seen   = 1'b0;
            r.status = vdit_pkg::ST_OK;
            hit      = 1'b0;
            free_idx = -1;
            idx      = int'(key[vdit_pkg::TBL_AW-1:0]);
            for (i = 0; i < vdit_pkg::TABLE_SLOTS; i++)
            begin
                if (!slot_used[idx])
                begin
                    free_idx = idx;
                    break;
                end
                if (slot_key[idx] == key)
                begin
                    r.offset = slot_ofs[idx][vdit_pkg::OFFSET_W-1:0];
                    r.seen   = 1'b1;
                    hit      = 1'b1;
                    break;
                end
                idx = (idx + 1) % vdit_pkg::TABLE_SLOTS;
            end

            if (hit)
                n_hits++;
            else if (free_idx < 0)
            begin
                r.status = vdit_pkg::ST_TABLE_FULL;
                n_tfull++;
            end
            else if (fill + run_words > vdit_pkg::BUFFER_WORDS)
            begin
                r.status = vdit_pkg::ST_BUFFER_FULL;
                n_bfull++;
            end
            else
            begin
                slot_used[free_idx] = 1'b1;
                slot_key[free_idx]  = key;
                slot_ofs[free_idx]  = fill;
                r.offset            = fill[vdit_pkg::OFFSET_W-1:0];
                fill                = fill + run_words;
                free_slots--;
                n_inserts++;
            end
            awaited.push_back(r);
            n_vectors++;
            zero_seed  = '0;
            first_seed = '0;
            tally      = 0;
            run_words  = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [vdit_pkg::OFFSET_W-1:0] ofs, logic seen,
                          logic [vdit_pkg::STATUS_W-1:0] st);
            lookup_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with nothing pending: offset %0d seen %0b status %0d",
                                 ofs, seen, st));
                return;
            end
            want = awaited.pop_front();
            if (ofs !== want.offset)
                report($sformatf("offset %0d, expected %0d", ofs, want.offset));
            if (seen !== want.seen)
                report($sformatf("seen_before %0b, expected %0b", seen, want.seen));
            if (st !== want.status)
                report($sformatf("status %0d, expected %0d", st, want.status));
        endtask
    endclass

    dedup_scoreboard             sb;
    logic [vdit_pkg::ELEM_W-1:0] vec_q[$];
    logic [vdit_pkg::ELEM_W-1:0] past_elems[$];
    int                          past_base[$];
    int                          past_len[$];
    bit                          gaps_on;
    int                          stall_cycles;

    vector_dedup_intern_table i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .element_bits (element_bits),
        .last_element (last_element),
        .done         (done),
        .offset       (offset),
        .seen_before  (seen_before),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(offset, seen_before, status);
        if (!rst_n || done || (start && !busy))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start        <= 1'b0;
            element_bits <= {$urandom, $urandom};
            last_element <= 1'($urandom_range(0, 1));
        end
    endtask

    task automatic send_element(logic [vdit_pkg::ELEM_W-1:0] e, logic last);
        if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
        @(negedge clk);
        start        <= 1'b1;
        element_bits <= e;
        last_element <= last;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_element(e, last);
    endtask

    task automatic send_vector(bit keep);
        int base;
        base = past_elems.size();
        foreach (vec_q[i]) send_element(vec_q[i], i == vec_q.size() - 1);
        if (keep && vec_q.size() <= 16 && past_len.size() < PAST_MAX)
        begin
            foreach (vec_q[i]) past_elems.push_back(vec_q[i]);
            past_base.push_back(base);
            past_len.push_back(vec_q.size());
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    function automatic logic [vdit_pkg::ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return vdit_pkg::NEG_ZERO_BITS;
            2:       return '1;
            3:       return 64'h7ff0_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void build_fresh(int n);
        int j;
        vec_q.delete();
        for (j = 0; j < n; j++) vec_q.push_back(pick_element());
    endfunction

    function automatic void load_past(bit swap_zero);
        int                          k;
        int                          j;
        logic [vdit_pkg::ELEM_W-1:0] e;
        k = $urandom_range(0, past_len.size() - 1);
        vec_q.delete();
        for (j = 0; j < past_len[k]; j++)
        begin
            e = past_elems[past_base[k] + j];
            if (swap_zero && e == '0)
                e = vdit_pkg::NEG_ZERO_BITS;
            else if (swap_zero && e == vdit_pkg::NEG_ZERO_BITS)
                e = '0;
            vec_q.push_back(e);
        end
    endfunction

    // solve the final element so the vector's key starts probing at the given slot
    function automatic void build_aimed(int slot, int n);
        logic [vdit_pkg::ELEM_W-1:0] key;
        logic [vdit_pkg::ELEM_W-1:0] h;
        logic [vdit_pkg::ELEM_W-1:0] tail;
        int                          j;
        do
        begin
            build_fresh(n - 1);
            h = '0;
            if (n == 3)
                h = sb.mix_step(sb.fold(vec_q[0]), sb.fold(vec_q[1]));
            else
                for (j = 0; j < n - 1; j++) h = sb.mix_step(h, sb.fold(vec_q[j]));
            key                          = {$urandom, $urandom};
            key[vdit_pkg::TBL_AW-1:0]    = slot[vdit_pkg::TBL_AW-1:0];
            tail = (key ^ h) - vdit_pkg::MIX_CONST - (h << 6) - (h >> 2);
        end
        while (tail == vdit_pkg::NEG_ZERO_BITS);
        vec_q.push_back(tail);
    endfunction

    function automatic int free_slot();
        int s;
        int j;
        s = $urandom_range(0, vdit_pkg::TABLE_SLOTS - 1);
        for (j = 0; j < vdit_pkg::TABLE_SLOTS; j++)
            if (!sb.slot_used[(s + j) % vdit_pkg::TABLE_SLOTS])
                return (s + j) % vdit_pkg::TABLE_SLOTS;
        return -1;
    endfunction

    initial
    begin
        int items;
        int nvec;
        bit keep;

        sb           = new();
        stall_cycles = 0;
        gaps_on      = 1'b1;
        rst_n        = 1'b0;
        start        = 1'b0;
        element_bits = '0;
        last_element = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero folding, seeded three-element key, tally saturation
        vec_q = '{64'h0};
        send_vector(1);
        vec_q = '{vdit_pkg::NEG_ZERO_BITS};
        send_vector(1);
        vec_q = '{64'hffff_ffff_ffff_ffff};
        send_vector(1);
        vec_q = '{64'h1, 64'h7ff0_0000_0000_0000, 64'hffff_ffff_ffff_ffff};
        send_vector(1);
        vec_q = '{64'h1, 64'h7ff0_0000_0000_0000, 64'hffff_ffff_ffff_ffff};
        send_vector(1);
        vec_q = '{vdit_pkg::NEG_ZERO_BITS, 64'h1};
        send_vector(1);
        vec_q = '{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h0,
                  vdit_pkg::NEG_ZERO_BITS};
        send_vector(1);
        vec_q = '{64'h7fef_ffff_ffff_ffff, 64'h1, 64'h8000_0000_0000_0001,
                  64'hffef_ffff_ffff_ffff, 64'h0};
        send_vector(1);
        vec_q = '{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                  vdit_pkg::NEG_ZERO_BITS, 64'h0};
        send_vector(1);
        drain();

        // random vectors with repeats for hits
        items = 0;
        nvec  = 0;
        while (items < RANDOM_ITEMS)
        begin
            if (nvec % 30 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (nvec % 47 == 46) drain();
            if (past_len.size() > 0 && $urandom_range(0, 9) < 3)
            begin
                load_past($urandom_range(0, 3) == 0);
                keep = 1'b0;
            end
            else
            begin
                build_fresh(($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                        : $urandom_range(1, 6));
                keep = 1'b1;
            end
            items += vec_q.size();
            send_vector(keep);
            nvec++;
        end

        // fill the table with single-element vectors, each aimed at a free slot
        gaps_on = 1'b0;
        while (sb.free_slots > 0)
        begin
            build_aimed(free_slot(), 1);
            send_vector(0);
        end

        // full table: misses refused, known vectors still found
        build_fresh(1);
        send_vector(0);
        load_past(1'b0);
        send_vector(0);
        build_fresh(3);
        send_vector(0);
        load_past(1'b1);
        send_vector(0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d vectors from %0d elements: %0d stored, %0d found again",
                 sb.n_vectors, sb.n_elems, sb.n_inserts, sb.n_hits);
        $display("refused on full table %0d, on full buffer %0d; buffer words in use %0d",
                 sb.n_tfull, sb.n_bfull, sb.fill);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/vdit_pkg.sv
rtl/core/vdit_ctrl.sv
rtl/core/vdit_dp.sv
rtl/core/vector_dedup_intern_table.sv
verif/vector_dedup_intern_table_tb.sv
